FILE: rtl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg: shared types and constants for the euler to quaternion datapath
// Word widths of the trig and product stages, the arctangent table and the
// output limit of the Q1.14 components.
// ----------------------------------------------------------------------------
`default_nettype none

package e2q_pkg;

  // half angle: 2^32 units per full turn
  localparam int HALF_W    = 32;
  // cordic working registers, q30 with headroom
  localparam int CORDIC_W  = 34;
  // sine and cosine words handed to the products, q30
  localparam int TRIG_W    = 32;
  // pair product after the q30 floor shift
  localparam int PAIR_W    = 34;
  // triple product, q60
  localparam int TRIP_W    = 64;
  // sum or difference of two triple products, q60
  localparam int SUM_W     = 65;
  // q60 to q14
  localparam int ROUND_SHIFT = 46;
  localparam int QUOT_W      = SUM_W - ROUND_SHIFT;
  localparam int OUT_W       = 16;

  localparam int NUM_LANES = 3;
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [SUM_W-1:0]    ROUND_BIAS  = 65'sh2000_0000_0000;
  localparam logic signed [QUOT_W-1:0]   OUT_LIMIT   = 19'sd16384;

  // atan(2^-i), 2^32 units per full turn
  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

endpackage

`default_nettype wire

FILE: rtl/e2q_cordic.sv
// ----------------------------------------------------------------------------
// e2q_cordic: pipelined rotation-mode cordic, three lanes
// One micro-rotation per register stage for roll, pitch and yaw half angles;
// a valid bit runs alongside the data.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_cordic
  import e2q_pkg::*;
#(
  parameter int STAGES = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic signed [HALF_W-1:0] in_angle [NUM_LANES],
  output logic                          out_valid,
  output trig_t                         out_trig [NUM_LANES]
);

  logic signed [CORDIC_W-1:0] x_in [NUM_LANES][STAGES];
  logic signed [CORDIC_W-1:0] y_in [NUM_LANES][STAGES];
  logic signed [CORDIC_W-1:0] z_in [NUM_LANES][STAGES];
  logic signed [CORDIC_W-1:0] x_q  [NUM_LANES][STAGES];
  logic signed [CORDIC_W-1:0] y_q  [NUM_LANES][STAGES];
  logic signed [CORDIC_W-1:0] z_q  [NUM_LANES][STAGES];
  logic [STAGES-1:0]          vld_q;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      x_in[l][0] = CORDIC_GAIN;
      y_in[l][0] = '0;
      z_in[l][0] = CORDIC_W'(in_angle[l]);
      for (int i = 1; i < STAGES; i++) begin
        x_in[l][i] = x_q[l][i-1];
        y_in[l][i] = y_q[l][i-1];
        z_in[l][i] = z_q[l][i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NUM_LANES; l++) begin
      for (int i = 0; i < STAGES; i++) begin
        // rotate toward zero residual angle
        if (!z_in[l][i][CORDIC_W-1]) begin
          x_q[l][i] <= x_in[l][i] - (y_in[l][i] >>> i);
          y_q[l][i] <= y_in[l][i] + (x_in[l][i] >>> i);
          z_q[l][i] <= z_in[l][i] - $signed(CORDIC_W'(ATAN_TURNS[i]));
        end else begin
          x_q[l][i] <= x_in[l][i] + (y_in[l][i] >>> i);
          y_q[l][i] <= y_in[l][i] - (x_in[l][i] >>> i);
          z_q[l][i] <= z_in[l][i] + $signed(CORDIC_W'(ATAN_TURNS[i]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[STAGES-2:0], in_valid};
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      out_trig[l].sin_v = $signed(y_q[l][STAGES-1][TRIG_W-1:0]);
      out_trig[l].cos_v = $signed(x_q[l][STAGES-1][TRIG_W-1:0]);
    end
  end

  assign out_valid = vld_q[STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/e2q_products.sv
// ----------------------------------------------------------------------------
// e2q_products: quaternion products, sums and output rounding
// Pair products, triple products, sums of two triples, then q14 rounding
// with saturation, one register stage each.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_products
  import e2q_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire trig_t                  roll,
  input  wire trig_t                  pitch,
  input  wire trig_t                  yaw,
  output logic                        out_valid,
  output logic signed [OUT_W-1:0]     quat_w,
  output logic signed [OUT_W-1:0]     quat_x,
  output logic signed [OUT_W-1:0]     quat_y,
  output logic signed [OUT_W-1:0]     quat_z
);

  logic signed [2*TRIG_W-1:0]      pm_cc, pm_ss, pm_sc, pm_cs;
  logic signed [PAIR_W-1:0]        p_cc, p_ss, p_sc, p_cs;
  logic signed [TRIG_W-1:0]        cy_d, sy_d;
  logic signed [PAIR_W+TRIG_W-1:0] tm [8];
  logic signed [TRIP_W-1:0]        t_q [8];
  logic signed [SUM_W-1:0]         s_w, s_x, s_y, s_z;
  logic signed [OUT_W-1:0]         q_w_next, q_x_next, q_y_next, q_z_next;
  logic                            v1, v2, v3;

  function automatic logic signed [OUT_W-1:0] to_q14(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0]  r;
    logic signed [QUOT_W-1:0] q;
    r = s + ROUND_BIAS;
    q = r[SUM_W-1:ROUND_SHIFT];
    if (q > OUT_LIMIT) begin
      q = OUT_LIMIT;
    end else if (q < -OUT_LIMIT) begin
      q = -OUT_LIMIT;
    end
    return q[OUT_W-1:0];
  endfunction

  // stage 1: roll times pitch pairs
  assign pm_cc = roll.cos_v * pitch.cos_v;
  assign pm_ss = roll.sin_v * pitch.sin_v;
  assign pm_sc = roll.sin_v * pitch.cos_v;
  assign pm_cs = roll.cos_v * pitch.sin_v;

  always_ff @(posedge clk) begin
    p_cc <= pm_cc[2*TRIG_W-1:30];
    p_ss <= pm_ss[2*TRIG_W-1:30];
    p_sc <= pm_sc[2*TRIG_W-1:30];
    p_cs <= pm_cs[2*TRIG_W-1:30];
    cy_d <= yaw.cos_v;
    sy_d <= yaw.sin_v;
  end

  // stage 2: times yaw, pairs of terms per component
  assign tm[0] = p_cc * cy_d;
  assign tm[1] = p_ss * sy_d;
  assign tm[2] = p_sc * cy_d;
  assign tm[3] = p_cs * sy_d;
  assign tm[4] = p_cs * cy_d;
  assign tm[5] = p_sc * sy_d;
  assign tm[6] = p_cc * sy_d;
  assign tm[7] = p_ss * cy_d;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      t_q[k] <= tm[k][TRIP_W-1:0];
    end
  end

  // stage 3: sums in q60
  always_ff @(posedge clk) begin
    s_w <= SUM_W'(t_q[0]) + SUM_W'(t_q[1]);
    s_x <= SUM_W'(t_q[2]) - SUM_W'(t_q[3]);
    s_y <= SUM_W'(t_q[4]) + SUM_W'(t_q[5]);
    s_z <= SUM_W'(t_q[6]) - SUM_W'(t_q[7]);
  end

  // stage 4: round and clamp
  assign q_w_next = to_q14(s_w);
  assign q_x_next = to_q14(s_x);
  assign q_y_next = to_q14(s_y);
  assign q_z_next = to_q14(s_z);

  always_ff @(posedge clk) begin
    quat_w <= q_w_next;
    quat_x <= q_x_next;
    quat_y <= q_y_next;
    quat_z <= q_z_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion: roll, pitch, yaw binary angles to attitude quaternion
// Pipelined cordic sine and cosine of the half angles, then the z-y-x
// product sums, rounded to q1.14 and clamped to plus or minus one.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low; busy
//   is only high while rst is asserted, so a new request can be issued on
//   every clock cycle.
//   roll_angle, pitch_angle and yaw_angle carry angle = value * pi / 2^(W-1),
//   W = ANGLE_WIDTH, taken from the low W bits of each port.
//   quat_w, quat_x, quat_y, quat_z are q1.14 and valid for exactly one cycle
//   while done is high; results leave in request order.
//   From the accepting edge to the edge that takes the result a request passes
//   one input register, one cordic stage per micro-rotation, then pair
//   product, triple product, sum and round stages. Throughput is one request
//   per cycle.
//   Reset clears every valid bit, so no done strobe follows reset until new
//   requests arrive. The receiver has no stall input and must take each
//   result in its done cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_quaternion
  import e2q_pkg::*;
#(
  parameter int ANGLE_WIDTH = 16,
  parameter int TRIG_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] roll_angle,
  input  wire logic signed [15:0] pitch_angle,
  input  wire logic signed [15:0] yaw_angle,
  output logic                    done,
  output logic signed [15:0]      quat_w,
  output logic signed [15:0]      quat_x,
  output logic signed [15:0]      quat_y,
  output logic signed [15:0]      quat_z
);

  localparam int NUM_STAGES = (TRIG_STAGES < ATAN_ENTRIES) ? TRIG_STAGES : ATAN_ENTRIES;
  localparam int LATENCY    = NUM_STAGES + 5;

  logic [31:0]              raw_ext   [NUM_LANES];
  logic signed [HALF_W-1:0] half_next [NUM_LANES];
  logic signed [HALF_W-1:0] half_q    [NUM_LANES];
  logic                     v0;
  logic                     trig_valid;
  trig_t                    trig      [NUM_LANES];

  assign busy = rst;

  assign raw_ext[LANE_ROLL]  = {16'b0, roll_angle};
  assign raw_ext[LANE_PITCH] = {16'b0, pitch_angle};
  assign raw_ext[LANE_YAW]   = {16'b0, yaw_angle};

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_half
    logic [ANGLE_WIDTH-1:0] bits;
    assign bits = ANGLE_WIDTH'(raw_ext[g]);
    if (ANGLE_WIDTH < 32) begin : g_scale
      assign half_next[g] = {bits[ANGLE_WIDTH-1], bits, {(31-ANGLE_WIDTH){1'b0}}};
    end else begin : g_halve
      // halve, rounding toward zero
      logic [32:0] adj;
      assign adj          = 33'($signed(bits)) + 33'(bits[ANGLE_WIDTH-1]);
      assign half_next[g] = $signed(adj[32:1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NUM_LANES; l++) begin
      half_q[l] <= half_next[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  e2q_cordic #(
    .STAGES (NUM_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .in_angle  (half_q),
    .out_valid (trig_valid),
    .out_trig  (trig)
  );

  e2q_products u_products (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (trig_valid),
    .roll      (trig[LANE_ROLL]),
    .pitch     (trig[LANE_PITCH]),
    .yaw       (trig[LANE_YAW]),
    .out_valid (done),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z)
  );

`ifndef SYNTHESIS
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching request");

  a_request_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("request produced no result");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (quat_w <= 16'sd16384 && quat_w >= -16'sd16384 &&
              quat_x <= 16'sd16384 && quat_x >= -16'sd16384 &&
              quat_y <= 16'sd16384 && quat_y >= -16'sd16384 &&
              quat_z <= 16'sd16384 && quat_z >= -16'sd16384))
    else $error("quaternion component outside plus or minus one");
`endif

endmodule

`default_nettype wire

FILE: dv/euler_to_quaternion_test.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion_test: self-checking bench for the euler to quaternion block
// A short table of angle triples comes first: zero, the extremes, quarter and
// half turns, and alternating bit patterns. Random triples follow under three
// mixes of sender idling. Each result is checked against a bit-true fixed point
// CORDIC and product predictor kept in this bench, or against typed-in values.
// ----------------------------------------------------------------------------

module euler_to_quaternion_test;

  localparam int ANGLE_W       = 16;
  localparam int TRIG_STAGES_P = 16;
  localparam int LATENCY       = (TRIG_STAGES_P < 24 ? TRIG_STAGES_P : 24) + 5;
  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int NUM_PHASES    = 3;
  localparam int TABLE_ROWS    = 23;

  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
  localparam longint Q14_ONE         = 64'sd16384;

  // atan(2^-i), 2^32 units per full turn
  localparam longint ATAN_TURN [24] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
    64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
    64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
    64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861,
    64'sd10430,     64'sd5215,      64'sd2608,      64'sd1304,
    64'sd652,       64'sd326,       64'sd163,       64'sd81
  };

  // which components of a table row are typed in rather than predicted
  localparam logic [3:0] CHK_NONE = 4'b0000;
  localparam logic [3:0] CHK_W    = 4'b1000;
  localparam logic [3:0] CHK_X    = 4'b0100;
  localparam logic [3:0] CHK_Y    = 4'b0010;
  localparam logic [3:0] CHK_Z    = 4'b0001;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic [3:0]         mask;
    quat_t              typed;
  } angle_row_t;

  localparam quat_t Q_NONE = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};

  angle_row_t angle_table [TABLE_ROWS] = '{
    '{16'sd0,     16'sd0,     16'sd0,     CHK_W, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0}},
    '{16'sh8000,  16'sd0,     16'sd0,     CHK_X, '{16'sd0, -16'sd16384, 16'sd0, 16'sd0}},
    '{16'sd0,     16'sh8000,  16'sd0,     CHK_Y, '{16'sd0, 16'sd0, -16'sd16384, 16'sd0}},
    '{16'sd0,     16'sd0,     16'sh8000,  CHK_Z, '{16'sd0, 16'sd0, 16'sd0, -16'sd16384}},
    '{16'sh8000,  16'sh8000,  16'sh8000,  CHK_W, '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0}},
    '{16'sh7fff,  16'sh7fff,  16'sh7fff,  CHK_NONE, Q_NONE},
    '{16'sh7fff,  16'sd0,     16'sd0,     CHK_NONE, Q_NONE},
    '{16'sd0,     16'sh7fff,  16'sd0,     CHK_NONE, Q_NONE},
    '{16'sd0,     16'sd0,     16'sh7fff,  CHK_NONE, Q_NONE},
    '{16'sd16384, 16'sd0,     16'sd0,     CHK_NONE, Q_NONE},
    '{-16'sd16384, 16'sd0,    16'sd0,     CHK_NONE, Q_NONE},
    '{16'sd0,     16'sd16384, 16'sd0,     CHK_NONE, Q_NONE},
    '{16'sd0,     16'sd0,     16'sd16384, CHK_NONE, Q_NONE},
    '{16'sd16384, 16'sd16384, 16'sd16384, CHK_NONE, Q_NONE},
    '{-16'sd16384, 16'sd16384, -16'sd16384, CHK_NONE, Q_NONE},
    '{16'sd1,     16'sd1,     16'sd1,     CHK_NONE, Q_NONE},
    '{-16'sd1,    -16'sd1,    -16'sd1,    CHK_NONE, Q_NONE},
    '{16'sh7fff,  16'sh8000,  16'sh7fff,  CHK_NONE, Q_NONE},
    '{16'sh8000,  16'sh7fff,  16'sh8000,  CHK_NONE, Q_NONE},
    '{16'sd8192,  -16'sd8192, 16'sd24576, CHK_NONE, Q_NONE},
    '{16'sd21845, -16'sd10923, 16'sd5461, CHK_NONE, Q_NONE},
    '{16'sh5555,  16'shaaaa,  16'sh5555,  CHK_NONE, Q_NONE},
    '{16'shaaaa,  16'sh5555,  16'shaaaa,  CHK_NONE, Q_NONE}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] roll_angle = '0;
  logic signed [15:0] pitch_angle = '0;
  logic signed [15:0] yaw_angle = '0;
  logic               done;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  // typed-in components that travel with the current request
  logic [3:0] req_mask = CHK_NONE;
  quat_t      req_typed = '0;

  quat_t quat_due [$];
  int    fail_count = 0;
  int    n_results = 0;
  int    n_sent = 0;
  int    stall_cycles = 0;

  euler_to_quaternion #(
    .ANGLE_WIDTH(ANGLE_W),
    .TRIG_STAGES(TRIG_STAGES_P)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .roll_angle(roll_angle),
    .pitch_angle(pitch_angle),
    .yaw_angle(yaw_angle),
    .done(done),
    .quat_w(quat_w),
    .quat_x(quat_x),
    .quat_y(quat_y),
    .quat_z(quat_z)
  );

  always #6 clk = ~clk;

  // rotation-mode cordic on the half angle, q30 sine and cosine
  function automatic void half_sin_cos(input logic signed [15:0] ang,
                                       output longint s, output longint c);
    longint x, yv, z, xs, ys, nx, ny;
    x  = CORDIC_GAIN_Q30;
    yv = 0;
    z  = longint'(ang) <<< (31 - ANGLE_W);
    for (int i = 0; i < TRIG_STAGES_P && i < 24; i++) begin
      xs = x >>> i;
      ys = yv >>> i;
      if (z >= 0) begin
        nx = x - ys;
        ny = yv + xs;
        z  = z - ATAN_TURN[i];
      end else begin
        nx = x + ys;
        ny = yv - xs;
        z  = z + ATAN_TURN[i];
      end
      x  = nx;
      yv = ny;
    end
    s = yv;
    c = x;
  endfunction

  // pair product floored back to q30, third factor kept exact in q60
  function automatic longint triple_q60(input longint a, input longint b, input longint c);
    return ((a * b) >>> 30) * c;
  endfunction

  function automatic logic signed [15:0] round_q14(input longint q60);
    longint v;
    v = (q60 + (64'sd1 <<< 45)) >>> 46;
    if (v > Q14_ONE)
      v = Q14_ONE;
    if (v < -Q14_ONE)
      v = -Q14_ONE;
    return v[15:0];
  endfunction

  function automatic quat_t predict_quat(input logic signed [15:0] r,
                                         input logic signed [15:0] p,
                                         input logic signed [15:0] y);
    longint sr, cr, sp, cp, sy, cy;
    quat_t  q;
    half_sin_cos(r, sr, cr);
    half_sin_cos(p, sp, cp);
    half_sin_cos(y, sy, cy);
    q.w = round_q14(triple_q60(cr, cp, cy) + triple_q60(sr, sp, sy));
    q.x = round_q14(triple_q60(sr, cp, cy) - triple_q60(cr, sp, sy));
    q.y = round_q14(triple_q60(cr, sp, cy) + triple_q60(sr, cp, sy));
    q.z = round_q14(triple_q60(cr, cp, sy) - triple_q60(sr, sp, cy));
    return q;
  endfunction

  // uniform words mostly, with a share of extremes, near quarter turns, small values and one-hot or one-cold words
  function automatic logic signed [15:0] pick_angle();
    logic signed [15:0] a;
    case ($urandom_range(9))
      6: begin
        case ($urandom_range(4))
          0: a = 16'sh8000;
          1: a = 16'sh7fff;
          2: a = 16'sd0;
          3: a = -16'sd1;
          default: a = 16'sd1;
        endcase
      end
      7: a = 16'(($urandom_range(3) << 14) + $urandom_range(8) - 4);
      8: a = 16'($urandom_range(128) - 64);
      9: begin
        a = 16'(1 << $urandom_range(15));
        if ($urandom_range(1) == 1)
          a = ~a;
      end
      default: a = 16'($urandom);
    endcase
    return a;
  endfunction

  task automatic issue(input logic signed [15:0] r, input logic signed [15:0] p,
                       input logic signed [15:0] y, input logic [3:0] mask,
                       input quat_t typed);
    start       <= 1'b1;
    roll_angle  <= r;
    pitch_angle <= p;
    yaw_angle   <= y;
    req_mask    <= mask;
    req_typed   <= typed;
    do @(posedge clk); while (busy !== 1'b0);
    n_sent++;
  endtask

  // start low, junk on the angle ports
  task automatic idle_cycle();
    start       <= 1'b0;
    roll_angle  <= 16'($urandom);
    pitch_angle <= 16'($urandom);
    yaw_angle   <= 16'($urandom);
    @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    quat_t got;
    quat_t want;
    if (!rst) begin
      if (done) begin
        got = {quat_w, quat_x, quat_y, quat_z};
        n_results++;
        if (quat_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d with no request pending: w=%0d x=%0d y=%0d z=%0d",
                     n_results, got.w, got.x, got.y, got.z);
        end else begin
          want = quat_due.pop_front();
          if (got.w !== want.w || got.x !== want.x || got.y !== want.y ||
              got.z !== want.z) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                       n_results, want.w, want.x, want.y, want.z,
                       got.w, got.x, got.y, got.z);
          end
        end
      end
      if (start && !busy) begin
        want = predict_quat(roll_angle, pitch_angle, yaw_angle);
        if ((req_mask & CHK_W) != 0)
          want.w = req_typed.w;
        if ((req_mask & CHK_X) != 0)
          want.x = req_typed.x;
        if ((req_mask & CHK_Y) != 0)
          want.y = req_typed.y;
        if ((req_mask & CHK_Z) != 0)
          want.z = req_typed.z;
        quat_due.push_back(want);
      end
    end
  end

  // a cycle with no request taken and no result out counts toward the limit
  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("euler_to_quaternion_test NOT OK");
      $finish;
    end
  end

  initial begin
    int idle_pct [NUM_PHASES];
    idle_pct = '{0, 64, 15};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < TABLE_ROWS; i++)
      issue(angle_table[i].roll, angle_table[i].pitch, angle_table[i].yaw,
            angle_table[i].mask, angle_table[i].typed);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES + 1; n++) begin
        while ($urandom_range(99) < idle_pct[ph])
          idle_cycle();
        // now and then let the pipeline run partly or fully empty
        if (idle_pct[ph] != 0 && $urandom_range(49) == 0)
          repeat ($urandom_range(LATENCY + 4, 1)) idle_cycle();
        issue(pick_angle(), pick_angle(), pick_angle(), CHK_NONE, Q_NONE);
      end
    end
    idle_cycle();

    while (quat_due.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (quat_due.size() != 0)
      fail_count += quat_due.size();

    $display("%0d requests sent (%0d table rows, rest random angle triples) under no idling,",
             n_sent, TABLE_ROWS);
    $display("64%% and 15%% sender idling; %0d quaternions checked, %0d failures",
             n_results, fail_count);
    if (fail_count == 0)
      $display("euler_to_quaternion_test OK");
    else
      $display("euler_to_quaternion_test NOT OK");
    $finish;
  end

endmodule
